/* hw/rtl/lfr_pkg.sv */
// ============================================================================
// lfr_pkg: shared types and constants of the literal find/replace block
// Holds the register indexes, the window cell control word and case folding.
// ============================================================================
`default_nettype none

package lfr_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PAT_BYTES = 3'd0;
    localparam logic [2:0] CFG_PAT_LEN   = 3'd1;
    localparam logic [2:0] CFG_REP_BYTES = 3'd2;
    localparam logic [2:0] CFG_REP_LEN   = 3'd3;
    localparam logic [2:0] CFG_REP_ALL   = 3'd4;
    localparam logic [2:0] CFG_IGN_CASE  = 3'd5;

    // Control word shared by every window cell
    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic ins;     // this cell receives the incoming byte
    } t_cell_ctl;

    // Fold ASCII upper case letters to lower case when enabled
    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/literal_find_replace.sv */
// ============================================================================
// literal_find_replace: streaming literal string find and replace
// Replaces the first or every non-overlapping occurrence of a literal pattern
// in each string, held in a row of window cells until a decision can be made.
// ============================================================================
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ---------------------------------------
//  s_*      in   s_tvalid / s_tready  tdata=in_byte, tuser=byte_valid,
//                                     tlast=end_of_string
//  m_*      out  m_tvalid / m_tready  tdata=out_byte,replace_total,
//                                     tuser=out_valid, tlast=out_last
//  cfg_*    in   cfg_we               cfg_idx, cfg_data (no read-back)
//
//  One byte is taken per cycle while the sequencer is idle and no word is
//  held; a byte yields at most one word, but a match yields the replacement
//  bytes through the replacement sequencer. At an end of string the bytes
//  left drain through the cell row one cell per cycle while no word is held.
//  Reset is synchronous and active low; the window needs no clearing pass.
//  A word held in the output register under a low m_tready freezes the
//  sequencer, the cells and the output register.
//
`default_nettype none

module literal_find_replace
    import lfr_pkg::*;
#(
    parameter int PATTERN_MAX     = 8,
    parameter int REPLACEMENT_MAX = 8,
    parameter int COUNT_BITS      = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire   [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire   [0:0] i_s_tuser,   // [0] byte_valid
    input  wire         i_s_tlast,   // end_of_string
    // output stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [23:8] replace_total
    output logic  [0:0] o_m_tuser,   // [0] out_valid
    output logic        o_m_tlast,   // out_last
    // configuration
    input  wire         i_cfg_we,
    input  wire   [2:0] i_cfg_idx,
    input  wire  [63:0] i_cfg_data
);

    localparam int FW     = $clog2(PATTERN_MAX + 1);
    localparam int RW     = $clog2(REPLACEMENT_MAX + 1);
    localparam int CW_EXT = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REP   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Configuration registers
    logic [63:0] r_pat;
    logic [3:0]  r_plen_cfg;
    logic [63:0] r_rep;
    logic [3:0]  r_rlen_cfg;
    logic        r_all;
    logic        r_icase;

    // Control state
    logic [1:0]            r_state, n_state;
    logic [FW-1:0]         r_fill, n_fill;
    logic [RW-1:0]         r_idx, n_idx;
    logic                  r_last, n_last;
    logic                  r_repl, n_repl;
    logic [COUNT_BITS-1:0] r_count, n_count;

    // Output register
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ou;
    logic        r_ol;
    logic [15:0] r_ot;

    logic [FW-1:0] plen, need, fa;
    logic [RW-1:0] rlen;
    logic          adv, acc, app, dec, allow, match, m;
    logic          shift;
    logic          w_v, w_u, w_l;
    logic [7:0]    w_b, rep_byte;
    logic [15:0]   w_t;
    logic [CW_EXT-1:0] cnt_ext;

    logic [7:0]             v   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] ins;

    // Saturate lengths to the window and replacement sizes
    assign plen = (r_plen_cfg > 4'(PATTERN_MAX)) ? FW'(PATTERN_MAX) : FW'(r_plen_cfg);
    assign rlen = (r_rlen_cfg > 4'(REPLACEMENT_MAX)) ? RW'(REPLACEMENT_MAX)
                                                     : RW'(r_rlen_cfg);
    assign need = (plen == '0) ? FW'(1) : plen;

    // Handshake
    assign adv        = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && adv;
    assign acc        = i_s_tvalid && o_s_tready;
    assign app        = i_s_tuser[0] && (r_fill < FW'(PATTERN_MAX));
    assign fa         = r_fill + FW'(app);
    assign dec        = (fa >= need);
    assign allow      = r_all || !r_repl;

    // Row of window cells
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        t_cell_ctl  ctl;
        logic [7:0] nbr;

        assign ins[i]    = acc && app && (r_fill == FW'(i));
        assign ctl.shift = shift;
        assign ctl.ins   = ins[i];
        if (i == PATTERN_MAX - 1) begin : g_tail
            assign nbr = 8'h00;
        end else begin : g_mid
            assign nbr = v[i+1];
        end

        lfr_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_byte (i_s_tdata),
            .i_nbr  (nbr),
            .i_pat  (r_pat[8*i +: 8]),
            .i_fold (r_icase),
            .o_byte (v[i]),
            .o_eq   (eq[i])
        );
    end

    // Combine cell compares over the pattern length
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (FW'(i) < plen && !eq[i]) begin
                match = 1'b0;
            end
        end
    end

    assign m        = dec && (plen != '0) && allow && match;
    assign rep_byte = 8'(r_rep >> {r_idx, 3'b000});

    // Sequence the words of each step
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_last  = r_last;
        n_repl  = r_repl;
        n_count = r_count;
        w_v     = 1'b0;
        w_u     = 1'b0;
        w_l     = 1'b0;
        w_b     = 8'h00;
        shift   = 1'b0;
        if (adv) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (m) begin
                            n_fill = '0;
                            n_repl = 1'b1;
                            if (r_count != '1) begin
                                n_count = r_count + COUNT_BITS'(1);
                            end
                            if (rlen != '0) begin
                                w_v = 1'b1;
                                w_u = 1'b1;
                                w_b = r_rep[7:0];
                                w_l = i_s_tlast && (rlen == RW'(1));
                                if (rlen != RW'(1)) begin
                                    n_state = ST_REP;
                                    n_idx   = RW'(1);
                                    n_last  = i_s_tlast;
                                end
                            end else if (i_s_tlast) begin
                                w_v = 1'b1;
                                w_l = 1'b1;
                            end
                        end else if (dec || (i_s_tlast && fa != '0)) begin
                            w_v    = 1'b1;
                            w_u    = 1'b1;
                            w_b    = v[0];
                            shift  = 1'b1;
                            n_fill = fa - FW'(1);
                            if (i_s_tlast) begin
                                w_l = (fa == FW'(1));
                                if (fa != FW'(1)) begin
                                    n_state = ST_FLUSH;
                                end
                            end
                        end else begin
                            n_fill = fa;
                            if (i_s_tlast) begin
                                w_v = 1'b1;
                                w_l = 1'b1;
                            end
                        end
                        if (i_s_tlast) begin
                            n_repl = 1'b0;
                        end
                    end
                end
                ST_REP: begin
                    w_v   = 1'b1;
                    w_u   = 1'b1;
                    w_b   = rep_byte;
                    n_idx = RW'(r_idx + 1'b1);
                    if (RW'(r_idx + 1'b1) == rlen) begin
                        w_l     = r_last;
                        n_state = ST_IDLE;
                    end
                end
                ST_FLUSH: begin
                    w_v    = 1'b1;
                    w_u    = 1'b1;
                    w_b    = v[0];
                    shift  = 1'b1;
                    n_fill = r_fill - FW'(1);
                    if (r_fill == FW'(1)) begin
                        w_l     = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
        // A new pattern length drops the pending window
        if (i_cfg_we && i_cfg_idx == CFG_PAT_LEN) begin
            n_fill = '0;
        end
    end

    // Clip the count for the result field
    assign cnt_ext = CW_EXT'(n_count);
    assign w_t     = (cnt_ext > CW_EXT'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_plen_cfg <= '0;
            r_rep      <= '0;
            r_rlen_cfg <= '0;
            r_all      <= 1'b0;
            r_icase    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAT_BYTES: r_pat      <= i_cfg_data;
                CFG_PAT_LEN:   r_plen_cfg <= i_cfg_data[3:0];
                CFG_REP_BYTES: r_rep      <= i_cfg_data;
                CFG_REP_LEN:   r_rlen_cfg <= i_cfg_data[3:0];
                CFG_REP_ALL:   r_all      <= i_cfg_data[0];
                CFG_IGN_CASE:  r_icase    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
            r_repl  <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_last  <= n_last;
            r_repl  <= n_repl;
            r_count <= n_count;
            if (adv) begin
                r_ov <= w_v;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (adv && w_v) begin
            r_ob <= w_b;
            r_ou <= w_u;
            r_ol <= w_l;
            r_ot <= w_t;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_ot, r_ob};
    assign o_m_tuser  = r_ou;
    assign o_m_tlast  = r_ol;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(PATTERN_MAX))
        else $error("window fill beyond window size");

    a_rep_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REP) |-> (r_idx != '0 && r_idx < rlen))
        else $error("replacement index out of range");

    a_flush_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_fill != '0))
        else $error("flush with empty window");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("replacement count decreased");

endmodule

`default_nettype wire

/* hw/rtl/lfr_cell.sv */
// ============================================================================
// lfr_cell: one byte slot of the pending window
// Holds one pending byte, compares it with its pattern byte and shifts toward
// the head of the window when the oldest byte leaves.
// ============================================================================
`default_nettype none

module lfr_cell
    import lfr_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctl  i_ctl,
    input  wire  [7:0] i_byte,   // incoming stream byte
    input  wire  [7:0] i_nbr,    // neighbor's current byte
    input  wire  [7:0] i_pat,    // pattern byte for this position
    input  wire        i_fold,
    output logic [7:0] o_byte,   // byte seen at this position this cycle
    output logic       o_eq
);

    logic [7:0] r_byte;

    // Present the incoming byte when it lands here
    assign o_byte = i_ctl.ins ? i_byte : r_byte;
    assign o_eq   = (fold(o_byte, i_fold) == fold(i_pat, i_fold));

    // Advance toward the head or load the incoming byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_nbr;
        end else if (i_ctl.ins) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire
